[sv/acm_pkg.sv]
// Shared types and constants for the adjacent cluster merge block.
package acm_pkg;

   localparam int ROW_BITS       = 10;
   localparam int COORD_BITS     = 24;
   localparam int MAG_BITS       = COORD_BITS;
   localparam int NORM_BITS      = 2 * COORD_BITS;
   localparam int HALF_BITS      = NORM_BITS / 2;
   localparam int CPL_BITS       = 16;
   localparam int Q_BITS         = CPL_BITS + 1;
   localparam int QSQ_BITS       = 2 * CPL_BITS + 1;
   localparam int PROD_BITS      = QSQ_BITS + HALF_BITS;
   localparam int RHS_BITS       = QSQ_BITS + NORM_BITS;
   localparam int LHS_SHIFT      = 2 * CPL_BITS;
   localparam int QUEUE_DEPTH    = 4;

   localparam logic [CPL_BITS-1:0] COUPLING_RESET = 16'd3277;
   localparam logic [Q_BITS-1:0]   Q_ONE          = 17'h10000;

   typedef struct packed {
      logic [ROW_BITS-1:0]          cloud_start;
      logic [ROW_BITS-1:0]          cloud_end;
      logic signed [COORD_BITS-1:0] mean_x;
      logic signed [COORD_BITS-1:0] mean_y;
      logic                         last_cloud;
   } req_type;

   typedef struct packed {
      logic [ROW_BITS-1:0] seg_start;
      logic [ROW_BITS-1:0] seg_end;
      logic                last_segment;
   } rsp_type;

   typedef struct packed {
      logic [ROW_BITS-1:0] cloud_start;
      logic [ROW_BITS-1:0] cloud_end;
      logic                last_cloud;
      logic                merge;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } qhead_type;

endpackage

[sv/acm_front.sv]
// Front end: squared norms, neighbour coupling test and the coupling register.
module acm_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  acm_pkg::req_type  req_payload,
   input  logic              csr_write_en,
   input  logic [15:0]       csr_write_data,
   input  logic              q_full,
   output logic              q_push,
   output acm_pkg::item_type q_item
);
   import acm_pkg::*;

   localparam int STAGES = 7;

   logic                  adv;
   logic [STAGES:1]       vld_ff, vld_in;
   item_type              row_ff [1:STAGES];
   logic [CPL_BITS-1:0]   coupling_ff, coupling_in;
   logic [QSQ_BITS-1:0]   qsq_ff;
   logic [Q_BITS-1:0]     q_val;

   logic [MAG_BITS-1:0]   mag_x_ff, mag_y_ff, mag_x_in, mag_y_in;
   logic [NORM_BITS-1:0]  sq_x_ff, sq_y_ff;
   logic [NORM_BITS-1:0]  nsq_ff;
   logic [NORM_BITS-1:0]  prev_nsq_ff;
   logic                  prev_open_ff, prev_open_in;
   logic [NORM_BITS-1:0]  mn_ff, mx_ff;
   logic                  open4_ff, open5_ff, open6_ff;
   logic [NORM_BITS-1:0]  mn5_ff, mn6_ff;
   logic [PROD_BITS-1:0]  p_lo_ff, p_hi_ff;
   logic [RHS_BITS-1:0]   rhs_ff, rhs_in, lhs;
   logic                  merge_in;

   assign adv       = !vld_ff[STAGES] || !q_full;
   assign req_stall = !adv;
   assign q_push    = vld_ff[STAGES] && !q_full;
   assign q_item    = row_ff[STAGES];

   assign vld_in      = adv ? {vld_ff[STAGES-1:1], req_valid} : vld_ff;
   assign coupling_in = csr_write_en ? csr_write_data : coupling_ff;
   assign q_val       = Q_ONE - {1'b0, coupling_ff};

   assign mag_x_in = req_payload.mean_x[COORD_BITS-1] ?
                     MAG_BITS'(~req_payload.mean_x + 1'b1) : MAG_BITS'(req_payload.mean_x);
   assign mag_y_in = req_payload.mean_y[COORD_BITS-1] ?
                     MAG_BITS'(~req_payload.mean_y + 1'b1) : MAG_BITS'(req_payload.mean_y);

   assign prev_open_in = (vld_ff[3] && adv) ? !row_ff[3].last_cloud : prev_open_ff;

   assign rhs_in = (RHS_BITS'(p_hi_ff) << HALF_BITS) + RHS_BITS'(p_lo_ff);
   assign lhs    = {1'b0, mn6_ff, {LHS_SHIFT{1'b0}}};
   assign merge_in = open6_ff && (lhs > rhs_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         coupling_ff  <= COUPLING_RESET;
         prev_open_ff <= 1'b0;
      end else begin
         vld_ff       <= vld_in;
         coupling_ff  <= coupling_in;
         prev_open_ff <= prev_open_in;
      end
   end

   always_ff @(posedge clock) begin
      qsq_ff <= QSQ_BITS'(q_val * q_val);
      if (adv) begin
         row_ff[1] <= '{cloud_start: req_payload.cloud_start,
                        cloud_end:   req_payload.cloud_end,
                        last_cloud:  req_payload.last_cloud,
                        merge:       1'b0};
         for (int i = 2; i < STAGES; i++) begin
            row_ff[i] <= row_ff[i-1];
         end
         row_ff[STAGES] <= '{cloud_start: row_ff[STAGES-1].cloud_start,
                             cloud_end:   row_ff[STAGES-1].cloud_end,
                             last_cloud:  row_ff[STAGES-1].last_cloud,
                             merge:       merge_in};

         mag_x_ff <= mag_x_in;
         mag_y_ff <= mag_y_in;
         sq_x_ff  <= NORM_BITS'(mag_x_ff * mag_x_ff);
         sq_y_ff  <= NORM_BITS'(mag_y_ff * mag_y_ff);
         nsq_ff   <= sq_x_ff + sq_y_ff;

         if (vld_ff[3]) begin
            prev_nsq_ff <= nsq_ff;
         end
         mn_ff    <= (nsq_ff < prev_nsq_ff) ? nsq_ff : prev_nsq_ff;
         mx_ff    <= (nsq_ff < prev_nsq_ff) ? prev_nsq_ff : nsq_ff;
         open4_ff <= prev_open_ff;

         p_lo_ff  <= PROD_BITS'(qsq_ff * mx_ff[HALF_BITS-1:0]);
         p_hi_ff  <= PROD_BITS'(qsq_ff * mx_ff[NORM_BITS-1:HALF_BITS]);
         mn5_ff   <= mn_ff;
         open5_ff <= open4_ff;

         rhs_ff   <= rhs_in;
         mn6_ff   <= mn5_ff;
         open6_ff <= open5_ff;
      end
   end

endmodule

[sv/acm_queue.sv]
// Short flop queue of classified clusters between front and back.
module acm_queue #(
   parameter int DEPTH = acm_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  acm_pkg::item_type  push_item,
   output logic               full,
   input  logic               pop,
   output acm_pkg::qhead_type head
);
   import acm_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type          mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_pop;

   assign full   = (count_ff == CNT_W'(DEPTH));
   assign do_pop = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.item  = mem_ff[rd_ptr_ff];

   assign wr_ptr_in = !push ? wr_ptr_ff :
                      (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = !do_pop ? rd_ptr_ff :
                      (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;

   always_comb begin
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[sv/acm_back.sv]
// Back end: segment tracking and the result output register.
module acm_back (
   input  logic               clock,
   input  logic               reset,
   input  acm_pkg::qhead_type head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output acm_pkg::rsp_type   rsp_payload
);
   import acm_pkg::*;

   logic                 out_vld_ff, out_vld_in;
   rsp_type              out_ff, out_in;
   logic [ROW_BITS-1:0]  start_ff, start_in, end_ff, end_in;
   logic                 open_ff, open_in;
   logic                 flush_ff, flush_in;
   logic                 load_ok, load, need_emit;
   item_type             it;

   assign it          = head.item;
   assign load_ok     = !out_vld_ff || !rsp_stall;
   assign need_emit   = (!it.merge && open_ff) || it.last_cloud;
   assign rsp_valid   = out_vld_ff;
   assign rsp_payload = out_ff;

   always_comb begin
      start_in = start_ff;
      end_in   = end_ff;
      open_in  = open_ff;
      flush_in = flush_ff;
      out_in   = out_ff;
      load     = 1'b0;
      pop      = 1'b0;
      if (flush_ff) begin
         if (load_ok) begin
            load     = 1'b1;
            out_in   = '{seg_start: start_ff, seg_end: end_ff, last_segment: 1'b1};
            flush_in = 1'b0;
            open_in  = 1'b0;
         end
      end else if (head.valid && (!need_emit || load_ok)) begin
         pop    = 1'b1;
         end_in = it.cloud_end;
         if (!it.merge) begin
            start_in = it.cloud_start;
         end
         if (!it.merge && open_ff) begin
            load     = 1'b1;
            out_in   = '{seg_start: start_ff, seg_end: end_ff, last_segment: 1'b0};
            flush_in = it.last_cloud;
            open_in  = 1'b1;
         end else if (it.last_cloud) begin
            load    = 1'b1;
            out_in  = '{seg_start: it.merge ? start_ff : it.cloud_start,
                        seg_end: it.cloud_end, last_segment: 1'b1};
            open_in = 1'b0;
         end else begin
            open_in = 1'b1;
         end
      end
      out_vld_in = load || (out_vld_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
         open_ff    <= 1'b0;
         flush_ff   <= 1'b0;
         start_ff   <= '0;
         end_ff     <= '0;
      end else begin
         out_vld_ff <= out_vld_in;
         open_ff    <= open_in;
         flush_ff   <= flush_in;
         start_ff   <= start_in;
         end_ff     <= end_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule

[sv/adjacent_cluster_merge.sv]
// Top level of the adjacent cluster merge block.
// Merges runs of neighbouring radar clusters whose squared norms lie within the
// coupling ratio into row segments. A cluster is taken every cycle, unless the
// queue is full, into a seven-stage front end (magnitudes, squares, norm,
// min/max against the previous norm, two split partial products, add and
// compare); the classified cluster then waits in a four-entry queue for the
// back end, which retires one cluster per cycle unless rsp_stall holds it; a
// final cluster that closes two segments emits the second from a flush state.
// The coupling register (Q0.16) is written through csr_write_en/csr_write_data
// and must only change while no beat is in flight.
module adjacent_cluster_merge #(
   parameter int QUEUE_DEPTH = acm_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  acm_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output acm_pkg::rsp_type rsp_payload,
   input  logic             csr_write_en,
   input  logic [15:0]      csr_write_data
);
   import acm_pkg::*;

   logic       q_full, q_push, q_pop;
   item_type   q_item;
   qhead_type  q_head;

   acm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_item         (q_item)
   );

   acm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head)
   );

   acm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (q_head),
      .pop         (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

[tb/tb_adjacent_cluster_merge.sv]
// Self-checking testbench for adjacent_cluster_merge: cluster lists in, merged segments checked.
module tb_adjacent_cluster_merge;
   timeunit 1ns;
   timeprecision 1ps;

   import acm_pkg::*;

   localparam int CYCLE_LIMIT   = 600000;
   localparam int SETTLE_CYCLES = 64;
   localparam int LIST_ITEMS    = 238;
   localparam int COORD_MAX     = 8388607;

   logic          clock          = 1'b0;
   logic          reset          = 1'b1;
   logic          req_valid      = 1'b0;
   logic          req_stall;
   req_type       req_payload    = '0;
   logic          rsp_valid;
   logic          rsp_stall      = 1'b0;
   rsp_type       rsp_payload;
   logic          csr_write_en   = 1'b0;
   logic [15:0]   csr_write_data = '0;

   // predictor state
   logic [CPL_BITS-1:0]  coupling_q     = COUPLING_RESET;
   logic [ROW_BITS-1:0]  seg_first      = '0;
   logic [ROW_BITS-1:0]  seg_last       = '0;
   logic [NORM_BITS-1:0] prior_norm_sq  = '0;
   logic                 seg_open       = 1'b0;

   rsp_type expected_segments[$];

   int send_idle_pct  = 0;
   int stall_pct      = 0;
   int cycles         = 0;
   int failures       = 0;
   int clouds_sent    = 0;
   int segments_seen  = 0;
   int lists_closed   = 0;
   int walk_mx        = 1000;
   int walk_my        = 1000;
   int next_row       = 0;

   adjacent_cluster_merge i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d segments outstanding", cycles,
                  expected_segments.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // relative distance test on squared norms, exact in 128 bits
   function automatic logic norms_couple(input logic [NORM_BITS-1:0] a,
                                         input logic [NORM_BITS-1:0] b);
      logic [NORM_BITS-1:0] lo_sq;
      logic [NORM_BITS-1:0] hi_sq;
      logic [127:0]         q;
      logic [127:0]         lhs;
      logic [127:0]         rhs;
      lo_sq = (a < b) ? a : b;
      hi_sq = (a < b) ? b : a;
      q     = 128'(Q_ONE) - 128'(coupling_q);
      lhs   = 128'(lo_sq) << LHS_SHIFT;
      rhs   = q * q * 128'(hi_sq);
      return lhs > rhs;
   endfunction

   task automatic predict_segments(input req_type c);
      logic [MAG_BITS-1:0]  ax;
      logic [MAG_BITS-1:0]  ay;
      logic [NORM_BITS-1:0] nsq;
      ax  = c.mean_x[COORD_BITS-1] ? -c.mean_x : c.mean_x;
      ay  = c.mean_y[COORD_BITS-1] ? -c.mean_y : c.mean_y;
      nsq = NORM_BITS'(ax) * NORM_BITS'(ax) + NORM_BITS'(ay) * NORM_BITS'(ay);
      if (seg_open && norms_couple(prior_norm_sq, nsq)) begin
         seg_last = c.cloud_end;
      end else begin
         if (seg_open)
            expected_segments.push_back('{seg_start: seg_first, seg_end: seg_last,
                                          last_segment: 1'b0});
         seg_first = c.cloud_start;
         seg_last  = c.cloud_end;
      end
      prior_norm_sq = nsq;
      seg_open      = 1'b1;
      if (c.last_cloud) begin
         expected_segments.push_back('{seg_start: seg_first, seg_end: seg_last,
                                       last_segment: 1'b1});
         seg_open = 1'b0;
         lists_closed++;
      end
   endtask

   task automatic check_segment(input rsp_type got);
      rsp_type want;
      if (expected_segments.size() == 0) begin
         failures++;
         if (failures <= 10)
            $display("unexpected segment start %0d end %0d last %0b",
                     got.seg_start, got.seg_end, got.last_segment);
      end else begin
         want = expected_segments.pop_front();
         segments_seen++;
         if (got.seg_start !== want.seg_start || got.seg_end !== want.seg_end ||
             got.last_segment !== want.last_segment) begin
            failures++;
            if (failures <= 10)
               $display("segment mismatch: expected start %0d end %0d last %0b, got %0d %0d %0b",
                        want.seg_start, want.seg_end, want.last_segment,
                        got.seg_start, got.seg_end, got.last_segment);
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         check_segment(rsp_payload);
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // entered and left at a rising edge; valid stays high into the next beat but for idle gaps
   task automatic send_cloud(input req_type c);
      req_valid   <= 1'b1;
      req_payload <= c;
      do @(posedge clock); while (req_stall);
      predict_segments(c);
      clouds_sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (expected_segments.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_coupling(input logic [CPL_BITS-1:0] value);
      settle();
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      coupling_q      = value;
   endtask

   function automatic req_type cloud(input int s, input int e, input int x, input int y,
                                     input logic last);
      req_type c;
      c.cloud_start = ROW_BITS'(s);
      c.cloud_end   = ROW_BITS'(e);
      c.mean_x      = COORD_BITS'(x);
      c.mean_y      = COORD_BITS'(y);
      c.last_cloud  = last;
      return c;
   endfunction

   function automatic int nudge(input int m);
      int d;
      d = $urandom_range(0, m / 32 + 1);
      m = $urandom_range(1) ? m + d : m - d;
      if (m < 0) m = 0;
      if (m > COORD_MAX) m = COORD_MAX;
      return m;
   endfunction

   // mostly neighbours of a drifting position, with jumps, zero norms and raw noise
   function automatic req_type next_cloud(input logic last);
      int mode;
      int s;
      int x;
      int y;
      int e;
      mode = $urandom_range(99);
      if (mode < 8)
         return cloud($urandom, $urandom, $urandom, $urandom, last);
      if (mode < 16) begin
         x = 0;
         y = 0;
      end else if (mode < 38) begin
         walk_mx = $urandom_range(0, COORD_MAX) >> $urandom_range(0, 22);
         walk_my = $urandom_range(0, COORD_MAX) >> $urandom_range(0, 22);
         x = walk_mx;
         y = walk_my;
      end else begin
         walk_mx = nudge(walk_mx);
         walk_my = nudge(walk_my);
         x = walk_mx;
         y = walk_my;
      end
      if ($urandom_range(1)) x = -x;
      if ($urandom_range(1)) y = -y;
      s = next_row;
      e = next_row + $urandom_range(0, 24);
      next_row = (e + 1) % 1024;
      return cloud(s, e, x, y, last);
   endfunction

   task automatic send_random_lists(input int count);
      int   sent;
      int   len;
      int   k;
      logic cut;
      sent = 0;
      while (sent < count) begin
         len = $urandom_range(1, 12);
         cut = ($urandom_range(9) == 0);
         for (k = 0; k < len && sent < count; k++) begin
            send_cloud(next_cloud(k == len - 1 && !cut));
            sent++;
         end
      end
   endtask

   task automatic test_special_lists();
      send_cloud(cloud(0, 1023, COORD_MAX, -8388608, 1'b1));
      // two zero norms, closed together
      send_cloud(cloud(1, 2, 0, 0, 1'b0));
      send_cloud(cloud(3, 4, 0, 0, 1'b1));
      // zero next to nonzero, then equal norms in different directions
      send_cloud(cloud(5, 6, 0, 0, 1'b0));
      send_cloud(cloud(7, 8, 256, 0, 1'b0));
      send_cloud(cloud(9, 10, 0, -256, 1'b0));
      send_cloud(cloud(11, 12, -256, 0, 1'b1));
      // largest norms, start after end
      send_cloud(cloud(1000, 3, -8388608, -8388608, 1'b0));
      send_cloud(cloud(1023, 0, -8388608, COORD_MAX, 1'b1));
      // last cluster fails to merge
      send_cloud(cloud(20, 30, 100, 0, 1'b0));
      send_cloud(cloud(31, 40, 100000, 0, 1'b1));
   endtask

   task automatic test_coupling_extremes();
      write_coupling(16'd0);
      send_cloud(cloud(50, 51, 512, 512, 1'b0));
      send_cloud(cloud(52, 53, -512, 512, 1'b1));
      write_coupling(16'hFFFF);
      send_cloud(cloud(60, 61, 256, 0, 1'b0));
      send_cloud(cloud(62, 63, COORD_MAX, 0, 1'b0));
      send_cloud(cloud(64, 65, 0, 0, 1'b1));
   endtask

   task automatic test_random_lists();
      int idle_mix[4];
      int stall_mix[4];
      int settings[8];
      int p;
      int k;
      idle_mix  = '{0, 82, 0, 34};
      stall_mix = '{0, 0, 82, 34};
      settings  = '{3277, 0, 65535, 6554, 1, 32768, $urandom_range(0, 65535), 3277};
      for (p = 0; p < 4; p++) begin
         for (k = 0; k < 2; k++) begin
            write_coupling(CPL_BITS'(settings[2 * p + k]));
            send_idle_pct = idle_mix[p];
            stall_pct     = stall_mix[p];
            send_random_lists(LIST_ITEMS);
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_special_lists();
      test_coupling_extremes();
      test_random_lists();
      settle();
      if (expected_segments.size() != 0)
         failures++;
      $display("%0d clusters sent, %0d lists closed, %0d segments checked",
               clouds_sent, lists_closed, segments_seen);
      $display("coupling from 0 to 65535 under four sender/receiver pressure mixes");
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d failures", failures);
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

[adjacent_cluster_merge.f]
sv/acm_pkg.sv
sv/acm_front.sv
sv/acm_queue.sv
sv/acm_back.sv
sv/adjacent_cluster_merge.sv
tb/tb_adjacent_cluster_merge.sv
